### sv/dgpe_pkg.sv
// ============================================================================
// Delta gamma posting encoder package
// Shared payload types and constants for the posting encoder.
// ============================================================================
package dgpe_pkg;

    localparam int POST_ID_W    = 32;
    localparam int ID_WIDTH_DEF = 32;
    localparam int BIT_TOTAL_W  = 38;
    localparam int ID_TOTAL_W   = 32;
    localparam int PEND_W       = 7;
    localparam int PEND_CNT_W   = 3;
    localparam int NB_W         = 4;

    typedef struct packed {
        logic signed [POST_ID_W-1:0] post_id;
        logic                        list_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]             code_byte;
        logic                   byte_last;
        logic [BIT_TOTAL_W-1:0] bit_total;
        logic [ID_TOTAL_W-1:0]  id_total;
    } t_out_item;

    typedef struct packed {
        logic [NB_W-1:0]       nbytes;
        logic [PEND_CNT_W-1:0] pend_cnt;
        logic [PEND_W-1:0]     pend_bits;
    } t_coder_ctl;

endpackage

### sv/delta_gamma_posting_encoder.sv
// ============================================================================
// Delta gamma posting encoder
// Encodes the gaps of a posting list as Elias gamma codes packed into bytes.
// ============================================================================
//
//  Channel  | Valid        | Stall        | Payload
//  ---------+--------------+--------------+------------------------------
//  Input    | i_in_valid   | o_in_stall   | i_in_data  (post_id, list_end)
//  Output   | o_out_valid  | i_out_stall  | o_out_data (code byte, totals)
//
//  A request held in the input register is coded into a byte buffer. Each id yields
//  zero to nine bytes, and the output drains one byte per cycle while not stalled.
//  The next request is coded in the cycle its predecessor's last byte leaves.
//  Reset clears the list state and empties both registers.
//  A stalled output holds its byte; the input stalls only while its register is full.
module delta_gamma_posting_encoder #(
    parameter int ID_WIDTH = dgpe_pkg::ID_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dgpe_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dgpe_pkg::t_out_item  o_out_data
);
    import dgpe_pkg::*;

    localparam int BW     = ((2*ID_WIDTH+13)/8)*8;
    localparam int NB_MAX = BW/8;

    logic                   r_in_valid;
    t_in_item               r_in;
    logic [ID_WIDTH-1:0]    r_prev;
    logic [PEND_W-1:0]      r_pend_bits;
    logic [PEND_CNT_W-1:0]  r_pend_cnt;
    logic [BIT_TOTAL_W-1:0] r_bit_cnt;
    logic [ID_TOTAL_W-1:0]  r_id_cnt;
    logic [BW-1:0]          r_buf;
    logic [NB_W-1:0]        r_nbytes;
    logic                   r_last;
    logic [BIT_TOTAL_W-1:0] r_bit_total;
    logic [ID_TOTAL_W-1:0]  r_id_total;

    logic [BW-1:0]          n_buf;
    t_coder_ctl             n_ctl;
    logic [ID_WIDTH-1:0]    n_prev;
    logic [BIT_TOTAL_W-1:0] n_bit_cnt;
    logic [ID_TOTAL_W-1:0]  n_id_cnt;
    logic [BIT_TOTAL_W-1:0] n_bit_total;
    logic [ID_TOTAL_W-1:0]  n_id_total;

    logic out_take;
    logic in_take;
    logic load;
    logic byte_last;

    dgpe_gap_coder #(
        .ID_WIDTH (ID_WIDTH)
    ) u_coder (
        .i_id        (r_in.post_id[ID_WIDTH-1:0]),
        .i_last      (r_in.list_end),
        .i_prev      (r_prev),
        .i_pend_bits (r_pend_bits),
        .i_pend_cnt  (r_pend_cnt),
        .i_bit_cnt   (r_bit_cnt),
        .i_id_cnt    (r_id_cnt),
        .o_buf       (n_buf),
        .o_ctl       (n_ctl),
        .o_prev      (n_prev),
        .o_bit_cnt   (n_bit_cnt),
        .o_id_cnt    (n_id_cnt),
        .o_bit_total (n_bit_total),
        .o_id_total  (n_id_total)
    );

    assign o_out_valid = (r_nbytes != '0);
    assign out_take    = o_out_valid && !i_out_stall;
    assign load        = r_in_valid &&
                         ((r_nbytes == '0) || ((r_nbytes == NB_W'(1)) && out_take));
    assign o_in_stall  = r_in_valid && !load;
    assign in_take     = i_in_valid && !o_in_stall;

    assign byte_last            = r_last && (r_nbytes == NB_W'(1));
    assign o_out_data.code_byte = r_buf[BW-1 -: 8];
    assign o_out_data.byte_last = byte_last;
    assign o_out_data.bit_total = byte_last ? r_bit_total : '0;
    assign o_out_data.id_total  = byte_last ? r_id_total : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_nbytes    <= '0;
            r_prev      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_bit_cnt   <= '0;
            r_id_cnt    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_nbytes    <= n_ctl.nbytes;
                r_prev      <= n_prev;
                r_pend_bits <= n_ctl.pend_bits;
                r_pend_cnt  <= n_ctl.pend_cnt;
                r_bit_cnt   <= n_bit_cnt;
                r_id_cnt    <= n_id_cnt;
            end else if (out_take) begin
                r_nbytes <= r_nbytes - NB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (load) begin
            r_buf       <= n_buf;
            r_last      <= r_in.list_end;
            r_bit_total <= n_bit_total;
            r_id_total  <= n_id_total;
        end else if (out_take) begin
            r_buf <= r_buf << 8;
        end
    end

    // The byte buffer never holds more bytes than one id can produce.
    a_nbytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbytes <= NB_W'(NB_MAX))
        else $error("byte count exceeds buffer depth");

    // The end of a list returns the list state to its reset values.
    a_list_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in.list_end) |=>
            (r_pend_cnt == '0 && r_prev == '0 && r_bit_cnt == '0 && r_id_cnt == '0))
        else $error("list state not cleared after list end");

    // Every list ends with at least one byte carrying the totals.
    a_list_end_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in.list_end) |=> (r_nbytes != '0 && r_last))
        else $error("list end produced no final byte");

    // A new request is coded only once the previous bytes are gone.
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_nbytes != '0) |-> (r_nbytes == NB_W'(1) && out_take))
        else $error("buffer overwritten before draining");

endmodule

### sv/dgpe_gap_coder.sv
// ============================================================================
// Delta gamma gap coder
// Forms the gap, its gamma code and the byte-aligned bit buffer for one id.
// ============================================================================
module dgpe_gap_coder #(
    parameter int ID_WIDTH = dgpe_pkg::ID_WIDTH_DEF
) (
    input  logic [ID_WIDTH-1:0]                 i_id,
    input  logic                                i_last,
    input  logic [ID_WIDTH-1:0]                 i_prev,
    input  logic [dgpe_pkg::PEND_W-1:0]         i_pend_bits,
    input  logic [dgpe_pkg::PEND_CNT_W-1:0]     i_pend_cnt,
    input  logic [dgpe_pkg::BIT_TOTAL_W-1:0]    i_bit_cnt,
    input  logic [dgpe_pkg::ID_TOTAL_W-1:0]     i_id_cnt,
    output logic [((2*ID_WIDTH+13)/8)*8-1:0]    o_buf,
    output dgpe_pkg::t_coder_ctl                o_ctl,
    output logic [ID_WIDTH-1:0]                 o_prev,
    output logic [dgpe_pkg::BIT_TOTAL_W-1:0]    o_bit_cnt,
    output logic [dgpe_pkg::ID_TOTAL_W-1:0]     o_id_cnt,
    output logic [dgpe_pkg::BIT_TOTAL_W-1:0]    o_bit_total,
    output logic [dgpe_pkg::ID_TOTAL_W-1:0]     o_id_total
);
    import dgpe_pkg::*;

    localparam int BW = ((2*ID_WIDTH+13)/8)*8;
    localparam int TW = $clog2(BW+1);
    localparam logic [BIT_TOTAL_W:0] BIT_MAX = {1'b0, {BIT_TOTAL_W{1'b1}}};

    logic [ID_WIDTH-1:0]    gap_raw;
    logic [ID_WIDTH-1:0]    gap;
    logic [TW-1:0]          nbits;
    logic [TW-1:0]          code_len;
    logic [TW-1:0]          total;
    logic [BW-1:0]          comb;
    logic [TW-3-1:0]        full;
    logic                   padded;
    logic [BIT_TOTAL_W:0]   bit_sum;
    logic [BIT_TOTAL_W-1:0] bit_next;
    logic [ID_TOTAL_W-1:0]  id_next;
    logic [PEND_W-1:0]      pend_keep;

    assign gap_raw = i_id - i_prev;
    assign gap     = (gap_raw == '0 || gap_raw[ID_WIDTH-1]) ? ID_WIDTH'(1) : gap_raw;

    always_comb begin
        nbits = '0;
        for (int i = 0; i < ID_WIDTH; i++) begin
            if (gap[i]) begin
                nbits = TW'(i + 1);
            end
        end
    end

    assign code_len = (nbits << 1) - TW'(1);
    assign total    = TW'(i_pend_cnt) + code_len;
    assign comb     = (BW'(i_pend_bits) << code_len) | BW'(gap);
    assign o_buf    = comb << (TW'(BW) - total);

    assign full      = total[TW-1:3];
    assign padded    = i_last && (total[2:0] != 3'd0);
    assign pend_keep = comb[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[2:0]);

    assign bit_sum  = {1'b0, i_bit_cnt} + (BIT_TOTAL_W+1)'(code_len);
    assign bit_next = (bit_sum >= BIT_MAX) ? BIT_MAX[BIT_TOTAL_W-1:0]
                                           : bit_sum[BIT_TOTAL_W-1:0];
    assign id_next  = i_id_cnt + ID_TOTAL_W'(1);

    assign o_ctl.nbytes    = NB_W'(full) + NB_W'(padded);
    assign o_ctl.pend_cnt  = i_last ? '0 : total[2:0];
    assign o_ctl.pend_bits = i_last ? '0 : pend_keep;
    assign o_prev          = i_last ? '0 : i_id;
    assign o_bit_cnt       = i_last ? '0 : bit_next;
    assign o_id_cnt        = i_last ? '0 : id_next;
    assign o_bit_total     = bit_next;
    assign o_id_total      = id_next;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Delta gamma posting encoder testbench
// Sends posting lists through the encoder under random idling on both sides.
// Each code byte, flag and total is checked against a gamma packing predictor.
// ============================================================================
module tb_top;
    import dgpe_pkg::*;

    localparam int ID_W     = ID_WIDTH_DEF;
    localparam int N_RANDOM = 350;
    localparam logic [BIT_TOTAL_W-1:0] BIT_TOTAL_MAX = '1;

    typedef struct {
        t_in_item req;
        bit       drain;
    } t_pending;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    t_pending  pending_reqs[$];
    t_out_item expected_bytes[$];
    t_out_item exp_byte;
    int        n_total         = 0;
    int        n_accepted      = 0;
    int        bytes_predicted = 0;
    int        bytes_seen      = 0;
    int        errors          = 0;
    int        phase           = 0;
    int        tx_idle_pct;
    int        rx_stall_pct;

    logic [ID_W-1:0]        prev_id   = '0;
    logic [7:0]             acc_bits  = '0;
    int                     acc_count = 0;
    logic [BIT_TOTAL_W-1:0] code_bits = '0;
    logic [ID_TOTAL_W-1:0]  id_count  = '0;

    delta_gamma_posting_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    assign tx_idle_pct  = (phase == 0) ? 35 : (phase == 1) ? 64 : 0;
    assign rx_stall_pct = (phase == 0) ? 64 : (phase == 1) ? 35 : 0;

    function automatic void append_code_bit(input logic b);
        t_out_item full;
        acc_bits = {acc_bits[6:0], b};
        acc_count++;
        if (code_bits != BIT_TOTAL_MAX) begin
            code_bits++;
        end
        if (acc_count == 8) begin
            full = '0;
            full.code_byte = acc_bits;
            expected_bytes.push_back(full);
            bytes_predicted++;
            acc_bits  = '0;
            acc_count = 0;
        end
    endfunction

    function automatic void predict_gamma_bytes(input t_in_item req);
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] gap;
        int              nbits;
        t_out_item       tail;
        cur = req.post_id[ID_W-1:0];
        gap = cur - prev_id;
        if (gap == '0 || gap[ID_W-1]) begin
            gap = 1;
        end
        prev_id = cur;
        id_count++;
        nbits = 0;
        for (int i = 0; i < ID_W; i++) begin
            if (gap[i]) begin
                nbits = i + 1;
            end
        end
        for (int i = 0; i < nbits - 1; i++) begin
            append_code_bit(1'b0);
        end
        for (int i = nbits - 1; i >= 0; i--) begin
            append_code_bit(gap[i]);
        end
        if (req.list_end) begin
            if (acc_count != 0) begin
                tail = '0;
                tail.code_byte = 8'(acc_bits << (8 - acc_count));
                expected_bytes.push_back(tail);
                bytes_predicted++;
            end
            tail = expected_bytes[expected_bytes.size() - 1];
            tail.byte_last = 1'b1;
            tail.bit_total = code_bits;
            tail.id_total  = id_count;
            expected_bytes[expected_bytes.size() - 1] = tail;
            prev_id   = '0;
            acc_bits  = '0;
            acc_count = 0;
            code_bits = '0;
            id_count  = '0;
        end
    endfunction

    task automatic queue_request(input logic [31:0] id, input logic last, input bit drain);
        t_pending p;
        p.req.post_id  = id;
        p.req.list_end = last;
        p.drain        = drain;
        pending_reqs.push_back(p);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_gamma_bytes(in_data);
                n_accepted++;
                phase <= (n_accepted * 3) / n_total;
            end
            if (!in_valid || !in_stall) begin
                if (pending_reqs.size() != 0
                        && !(pending_reqs[0].drain && bytes_predicted != bytes_seen)
                        && $urandom_range(0, 99) >= tx_idle_pct) begin
                    in_data  <= pending_reqs[0].req;
                    in_valid <= 1'b1;
                    void'(pending_reqs.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            if (out_valid && !out_stall) begin
                bytes_seen <= bytes_seen + 1;
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected code byte %h", $time, out_data.code_byte);
                    errors++;
                end else begin
                    exp_byte = expected_bytes.pop_front();
                    if (out_data.code_byte !== exp_byte.code_byte
                            || out_data.byte_last !== exp_byte.byte_last
                            || out_data.bit_total !== exp_byte.bit_total
                            || out_data.id_total !== exp_byte.id_total) begin
                        $display("%0t: mismatch: expected byte %h last %b bits %0d ids %0d",
                                 $time, exp_byte.code_byte, exp_byte.byte_last,
                                 exp_byte.bit_total, exp_byte.id_total);
                        $display("%0t:           actual byte %h last %b bits %0d ids %0d",
                                 $time, out_data.code_byte, out_data.byte_last,
                                 out_data.bit_total, out_data.id_total);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] id;
        logic [31:0] step;
        int          len;
        int          n_rand;

        queue_request(32'h0000_0000, 1'b1, 1'b0);
        for (int i = 1; i <= 7; i++) begin
            queue_request(i, 1'b0, 1'b0);
        end
        queue_request(32'h8000_0006, 1'b1, 1'b0);
        queue_request(32'h0000_0001, 1'b0, 1'b0);
        queue_request(32'h0000_0009, 1'b1, 1'b0);
        queue_request(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_request(32'h8000_0000, 1'b0, 1'b0);
        queue_request(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_request(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_request(32'h0000_0005, 1'b0, 1'b0);
        queue_request(32'h0000_0002, 1'b0, 1'b0);
        queue_request(32'hC000_0000, 1'b0, 1'b0);
        queue_request(32'h4000_0000, 1'b0, 1'b1);
        queue_request(32'hBFFF_FFFF, 1'b1, 1'b0);
        queue_request(32'h8000_0000, 1'b1, 1'b0);

        // Most lists climb by gaps of random bit length; a few ids jump anywhere.
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            len = $urandom_range(1, 24);
            id  = '0;
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    id = $urandom;
                end else begin
                    step = $urandom & ((32'd1 << $urandom_range(0, 31)) - 32'd1);
                    id   = id + step;
                end
                queue_request(id, j == len - 1, $urandom_range(0, 99) == 0);
                n_rand++;
            end
        end
        n_total = pending_reqs.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_accepted < n_total || bytes_predicted != bytes_seen) begin
            @(posedge i_clk);
        end
        repeat (32) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
